// ===== sv/tgp_pkg.sv =====
`default_nettype none

package tgp_pkg;

    localparam int GLYPH_SIZE      = 8;
    localparam int COORD_BITS_DEF  = 13;

    localparam int REG_BITS        = 12;
    localparam int BANK_BITS       = 2;
    localparam int CHAR_BITS       = 8;
    localparam int SHEET_BITS      = 9;
    localparam int SCREEN_BITS     = 13;
    localparam int GLYPH_BITS      = 6;
    localparam int CFG_IDX_BITS    = 3;

    localparam logic [SHEET_BITS-1:0] SHEET_BASE_Y  = 9'd250;
    localparam logic [SHEET_BITS-1:0] BANK_STEP_Y   = 9'd28;
    localparam logic [GLYPH_BITS-1:0] OTHER_GLYPH   = 6'd38;
    localparam logic [GLYPH_BITS-1:0] DIGIT_GLYPHS  = 6'd10;
    localparam int                    GLYPHS_PER_ROW = 16;

    localparam logic [REG_BITS-1:0] SCREEN_WIDTH_RST  = 12'd224;
    localparam logic [REG_BITS-1:0] SCREEN_HEIGHT_RST = 12'd256;

    localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_BITS-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CASE_MASK    = 8'hDF;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_COL     = 3'd0,
        CFG_START_ROW     = 3'd1,
        CFG_COLOUR_BANK   = 3'd2,
        CFG_SCREEN_WIDTH  = 3'd3,
        CFG_SCREEN_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [SHEET_BITS-1:0] sheet_x;
        logic [SHEET_BITS-1:0] sheet_y;
    } t_glyph_src;

endpackage

`default_nettype wire

// ===== sv/tgp_glyph_map.sv =====
`default_nettype none

module tgp_glyph_map (
    input  wire logic [tgp_pkg::CHAR_BITS-1:0] i_char_code,
    input  wire logic [tgp_pkg::BANK_BITS-1:0] i_colour_bank,
    output tgp_pkg::t_glyph_src                o_src
);

    logic [tgp_pkg::CHAR_BITS-1:0]  up_char;
    logic [tgp_pkg::GLYPH_BITS-1:0] glyph;
    logic [tgp_pkg::SHEET_BITS-1:0] bank_off;

    assign up_char = i_char_code & tgp_pkg::CASE_MASK;

    always_comb begin
        if (i_char_code >= tgp_pkg::CHAR_ZERO && i_char_code <= tgp_pkg::CHAR_NINE) begin
            glyph = tgp_pkg::GLYPH_BITS'(i_char_code - tgp_pkg::CHAR_ZERO);
        end else if (up_char >= tgp_pkg::CHAR_UPPER_A && up_char <= tgp_pkg::CHAR_UPPER_Z) begin
            glyph = tgp_pkg::GLYPH_BITS'(up_char - tgp_pkg::CHAR_UPPER_A)
                    + tgp_pkg::DIGIT_GLYPHS;
        end else begin
            glyph = tgp_pkg::OTHER_GLYPH;
        end
    end

    // 16 glyphs to a sheet row, one pixel of margin on the left
    assign bank_off = tgp_pkg::SHEET_BITS'(i_colour_bank) * tgp_pkg::BANK_STEP_Y;

    assign o_src.sheet_x = tgp_pkg::SHEET_BITS'(1)
        + tgp_pkg::SHEET_BITS'(glyph % tgp_pkg::GLYPHS_PER_ROW)
          * tgp_pkg::SHEET_BITS'(tgp_pkg::GLYPH_SIZE);
    assign o_src.sheet_y = tgp_pkg::SHEET_BASE_Y + bank_off
        + tgp_pkg::SHEET_BITS'(glyph / tgp_pkg::GLYPHS_PER_ROW)
          * tgp_pkg::SHEET_BITS'(tgp_pkg::GLYPH_SIZE);

endmodule

`default_nettype wire

// ===== sv/text_glyph_placer.sv =====
// Text glyph placer: one text byte in, one placement request out.
// Input channel: i_in_valid / o_in_stall with i_char_code and i_last_char.
// Output channel: o_out_valid / i_out_stall with o_draw, sheet and screen
// coordinates and o_halted. Every byte gives exactly one result; when
// o_draw is low all coordinates are zero.
// Configuration: i_cfg_valid / o_cfg_ready (always ready), i_cfg_index picks
// start column, start row, colour bank, screen width or screen height.
// Writing a start register also moves the cursor there. Write only while idle.
// A byte taken sits in the input register; its result is computed from it
// and loaded into the output register, from which it is taken. Throughput
// is one byte per cycle while the output register can move; the cursor
// update lies combinationally between the two registers.
// Reset (synchronous, active low) empties both registers, restores the
// register defaults and puts the cursor at the start position.
// A stalled result holds; the input register takes bytes while it is empty or
// while the output register can move, so a stall with the input register full
// reaches o_in_stall in the same cycle. The cursor returns to the start and the
// stop flag clears after a byte flagged as last.
`default_nettype none

module text_glyph_placer #(
    parameter int COORD_BITS = tgp_pkg::COORD_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [tgp_pkg::CHAR_BITS-1:0]       i_char_code,
    input  wire logic                                i_last_char,

    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_draw,
    output logic [tgp_pkg::SHEET_BITS-1:0]           o_sheet_x,
    output logic [tgp_pkg::SHEET_BITS-1:0]           o_sheet_y,
    output logic [tgp_pkg::SCREEN_BITS-1:0]          o_screen_x,
    output logic [tgp_pkg::SCREEN_BITS-1:0]          o_screen_y,
    output logic                                     o_halted,

    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [tgp_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire logic [tgp_pkg::REG_BITS-1:0]        i_cfg_data
);

    localparam int CmpW = ((COORD_BITS >= tgp_pkg::REG_BITS) ? COORD_BITS
                                                             : tgp_pkg::REG_BITS) + 1;
    localparam logic [COORD_BITS-1:0] Step = COORD_BITS'(tgp_pkg::GLYPH_SIZE);

    // configuration
    logic [tgp_pkg::REG_BITS-1:0]  r_start_col;
    logic [tgp_pkg::REG_BITS-1:0]  r_start_row;
    logic [tgp_pkg::BANK_BITS-1:0] r_colour_bank;
    logic [tgp_pkg::REG_BITS-1:0]  r_screen_width;
    logic [tgp_pkg::REG_BITS-1:0]  r_screen_height;

    // cursor state
    logic [COORD_BITS-1:0] r_cursor_x, n_cursor_x;
    logic [COORD_BITS-1:0] r_cursor_y, n_cursor_y;
    logic                  r_stopped, n_stopped;

    // input register
    logic                          r_in_valid;
    logic [tgp_pkg::CHAR_BITS-1:0] r_char;
    logic                          r_last;

    // result register
    logic                            r_out_valid;
    logic                            r_draw, n_draw;
    logic [tgp_pkg::SHEET_BITS-1:0]  r_sheet_x, n_sheet_x;
    logic [tgp_pkg::SHEET_BITS-1:0]  r_sheet_y, n_sheet_y;
    logic [tgp_pkg::SCREEN_BITS-1:0] r_screen_x, n_screen_x;
    logic [tgp_pkg::SCREEN_BITS-1:0] r_screen_y, n_screen_y;
    logic                            r_halted, n_halted;

    logic                 cfg_wr;
    logic                 out_advance;
    logic                 in_load;
    tgp_pkg::t_glyph_src  glyph_src;

    logic                  is_newline;
    logic                  is_space;
    logic [COORD_BITS-1:0] base_x;
    logic                  wrap;
    logic [COORD_BITS-1:0] wrap_x;
    logic [COORD_BITS-1:0] wrap_y;
    logic                  stop_now;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    assign out_advance = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !out_advance;
    assign in_load     = i_in_valid && !o_in_stall;

    tgp_glyph_map u_glyph_map (
        .i_char_code   (r_char),
        .i_colour_bank (r_colour_bank),
        .o_src         (glyph_src)
    );

    assign is_newline = (r_char == tgp_pkg::CHAR_NEWLINE);
    assign is_space   = (r_char == tgp_pkg::CHAR_SPACE);

    // a space steps first, then both it and a glyph wrap on the same test
    assign base_x   = is_space ? r_cursor_x + Step : r_cursor_x;
    assign wrap     = (CmpW'(base_x) + CmpW'(tgp_pkg::GLYPH_SIZE)) > CmpW'(r_screen_width);
    assign wrap_x   = wrap ? COORD_BITS'(r_start_col) : base_x;
    assign wrap_y   = wrap ? r_cursor_y + Step : r_cursor_y;
    assign stop_now = CmpW'(wrap_y) > CmpW'(r_screen_height);

    always_comb begin
        n_cursor_x = r_cursor_x;
        n_cursor_y = r_cursor_y;
        n_stopped  = r_stopped;
        n_draw     = 1'b0;
        n_sheet_x  = '0;
        n_sheet_y  = '0;
        n_screen_x = '0;
        n_screen_y = '0;

        if (out_advance && !r_stopped) begin
            if (is_newline) begin
                n_cursor_x = COORD_BITS'(r_start_col);
                n_cursor_y = r_cursor_y + Step;
            end else begin
                n_cursor_x = wrap_x;
                n_cursor_y = wrap_y;
                if (stop_now) begin
                    n_stopped = 1'b1;
                end else if (!is_space) begin
                    n_draw     = 1'b1;
                    n_sheet_x  = glyph_src.sheet_x;
                    n_sheet_y  = glyph_src.sheet_y;
                    n_screen_x = tgp_pkg::SCREEN_BITS'(wrap_x);
                    n_screen_y = tgp_pkg::SCREEN_BITS'(wrap_y);
                    n_cursor_x = wrap_x + Step;
                end
            end
        end

        n_halted = n_stopped;

        // end of string: back to the start position
        if (out_advance && r_last) begin
            n_cursor_x = COORD_BITS'(r_start_col);
            n_cursor_y = COORD_BITS'(r_start_row);
            n_stopped  = 1'b0;
        end

        if (cfg_wr && i_cfg_index == tgp_pkg::CFG_START_COL) begin
            n_cursor_x = COORD_BITS'(i_cfg_data);
        end
        if (cfg_wr && i_cfg_index == tgp_pkg::CFG_START_ROW) begin
            n_cursor_y = COORD_BITS'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_col     <= '0;
            r_start_row     <= '0;
            r_colour_bank   <= '0;
            r_screen_width  <= tgp_pkg::SCREEN_WIDTH_RST;
            r_screen_height <= tgp_pkg::SCREEN_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                tgp_pkg::CFG_START_COL:     r_start_col     <= i_cfg_data;
                tgp_pkg::CFG_START_ROW:     r_start_row     <= i_cfg_data;
                tgp_pkg::CFG_COLOUR_BANK:   r_colour_bank   <= i_cfg_data[tgp_pkg::BANK_BITS-1:0];
                tgp_pkg::CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                tgp_pkg::CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x  <= '0;
            r_cursor_y  <= '0;
            r_stopped   <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cursor_x <= n_cursor_x;
            r_cursor_y <= n_cursor_y;
            r_stopped  <= n_stopped;
            if (in_load) begin
                r_in_valid <= 1'b1;
            end else if (out_advance) begin
                r_in_valid <= 1'b0;
            end
            if (out_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_char <= i_char_code;
            r_last <= i_last_char;
        end
        if (out_advance) begin
            r_draw     <= n_draw;
            r_sheet_x  <= n_sheet_x;
            r_sheet_y  <= n_sheet_y;
            r_screen_x <= n_screen_x;
            r_screen_y <= n_screen_y;
            r_halted   <= n_halted;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_draw      = r_draw;
    assign o_sheet_x   = r_sheet_x;
    assign o_sheet_y   = r_sheet_y;
    assign o_screen_x  = r_screen_x;
    assign o_screen_y  = r_screen_y;
    assign o_halted    = r_halted;

    a_halt_no_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_halted) |-> !o_draw)
        else $error("glyph drawn on a halted request");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_draw) |-> (o_sheet_x == '0 && o_sheet_y == '0
                                      && o_screen_x == '0 && o_screen_y == '0))
        else $error("non-drawing request carries coordinates");

    a_sheet_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_draw) |-> (o_sheet_x[2:0] == 3'd1))
        else $error("sheet column off the glyph grid");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_advance && r_last) |=> !r_stopped)
        else $error("stop flag survived the end of a string");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room downstream");

endmodule

`default_nettype wire
